@@ rtl/cnb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_pkg: shared types for the categorical naive Bayes classifier
// Controller states, command and status structs.
// ----------------------------------------------------------------------------
package cnb_pkg;

    localparam int Q_BITS = 17;

    typedef enum logic [3:0] {
        t_ST_IDLE,
        t_ST_CLEAR,
        t_ST_TR_RD,
        t_ST_TR_WR,
        t_ST_CLS,
        t_ST_PRIOR,
        t_ST_FV_RD,
        t_ST_RATIO,
        t_ST_MUL,
        t_ST_CMP,
        t_ST_OUT
    } t_state;

    typedef struct packed {
        logic clr_start;   // begin clear sweep / reset counters
        logic clr_step;    // write zero, advance sweep
        logic tr_capture;  // latch input item
        logic tr_read;     // issue feature count read
        logic tr_write;    // write back incremented counts
        logic pr_start;    // begin predict walk
        logic div_prior;   // start prior division
        logic fv_read;     // read count for current feature
        logic div_ratio;   // start ratio division
        logic mul;         // score *= ratio
        logic cmp;         // compare and advance class
        logic next_feat;   // advance feature
        logic skip_cls;    // advance class without compare
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic tr_last;     // last feature of train
        logic cls_zero;    // current class count is zero
        logic cls_last;    // current class is the last one
        logic feat_last;
        logic div_busy;
    } t_sts;

endpackage

@@ rtl/cnb_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_divider: radix-2 restoring divider
// Computes floor(num * 2^16 / den) saturated to Q1.16, one bit per cycle.
// ----------------------------------------------------------------------------
module cnb_divider #(
    parameter int COUNT_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [COUNT_BITS-1:0] i_num,
    input  logic [COUNT_BITS-1:0] i_den,
    output logic                  o_busy,
    output logic [16:0]           o_quot
);
    import cnb_pkg::*;

    localparam int NB   = COUNT_BITS + 16;
    localparam int CW   = $clog2(NB + 1);

    logic [NB-1:0]       r_dvd, n_dvd;
    logic [COUNT_BITS:0] r_rem, n_rem;
    logic [COUNT_BITS-1:0] r_den;
    logic [CW-1:0]       r_cnt;
    logic [COUNT_BITS:0] w_trial;
    logic [COUNT_BITS+1:0] w_diff;

    always_comb begin
        w_trial = {r_rem[COUNT_BITS-1:0], r_dvd[NB-1]};
        w_diff  = {1'b0, w_trial} - {2'b0, r_den};
        n_dvd   = {r_dvd[NB-2:0], ~w_diff[COUNT_BITS+1]};
        n_rem   = w_diff[COUNT_BITS+1] ? w_trial : w_diff[COUNT_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CW'(NB);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_start) begin
            r_dvd <= {i_num, 16'b0};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    always_comb begin
        if (r_den == '0) o_quot = '0;
        else if (r_dvd[NB-1:Q_BITS] != '0) o_quot = '1;
        else o_quot = r_dvd[Q_BITS-1:0];
    end
endmodule

@@ rtl/cnb_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_ctrl: controller state machine
// Sequences clear sweep, training updates and the predict walk.
// ----------------------------------------------------------------------------
module cnb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_mode,
    input  logic          i_out_stall,
    input  cnb_pkg::t_sts i_sts,
    output logic          o_stall,
    output logic          o_valid,
    output cnb_pkg::t_cmd o_cmd
);
    import cnb_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= t_ST_CLEAR;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            t_ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_done) n_state = t_ST_IDLE;
            end
            t_ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.tr_capture = 1'b1;
                    if (i_mode) begin
                        o_cmd.pr_start = 1'b1;
                        n_state = t_ST_CLS;
                    end else begin
                        n_state = t_ST_TR_RD;
                    end
                end
            end
            t_ST_TR_RD: begin
                o_cmd.tr_read = 1'b1;
                n_state = t_ST_TR_WR;
            end
            t_ST_TR_WR: begin
                o_cmd.tr_write = 1'b1;
                o_cmd.next_feat = 1'b1;
                n_state = i_sts.tr_last ? t_ST_IDLE : t_ST_TR_RD;
            end
            t_ST_CLS: begin
                if (i_sts.cls_zero) begin
                    o_cmd.skip_cls = 1'b1;
                    if (i_sts.cls_last) n_state = t_ST_OUT;
                end else begin
                    o_cmd.div_prior = 1'b1;
                    n_state = t_ST_PRIOR;
                end
            end
            t_ST_PRIOR: begin
                if (!i_sts.div_busy) begin
                    o_cmd.fv_read = 1'b1;
                    n_state = t_ST_FV_RD;
                end
            end
            t_ST_FV_RD: begin
                o_cmd.div_ratio = 1'b1;
                n_state = t_ST_RATIO;
            end
            t_ST_RATIO: begin
                if (!i_sts.div_busy) n_state = t_ST_MUL;
            end
            t_ST_MUL: begin
                o_cmd.mul = 1'b1;
                o_cmd.next_feat = 1'b1;
                if (i_sts.feat_last) begin
                    n_state = t_ST_CMP;
                end else begin
                    o_cmd.fv_read = 1'b1;
                    n_state = t_ST_FV_RD;
                end
            end
            t_ST_CMP: begin
                o_cmd.cmp = 1'b1;
                n_state = i_sts.cls_last ? t_ST_OUT : t_ST_CLS;
            end
            t_ST_OUT: begin
                o_valid = 1'b1;
                if (!i_out_stall) n_state = t_ST_IDLE;
            end
            default: n_state = t_ST_IDLE;
        endcase
    end
endmodule

@@ rtl/cnb_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_datapath: count tables, shared divider, multiplier and best tracker
// ----------------------------------------------------------------------------
module cnb_datapath #(
    parameter int NUM_CLASSES  = 8,
    parameter int NUM_FEATURES = 4,
    parameter int NUM_VALUES   = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cnb_pkg::t_cmd i_cmd,
    input  logic          i_label_in,
    input  logic [2:0]    i_label,
    input  logic [15:0]   i_feats,
    output cnb_pkg::t_sts o_sts,
    output logic [2:0]    o_predicted_label,
    output logic          o_label_valid
);
    import cnb_pkg::*;

    localparam int CB    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int FB    = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
    localparam int VB    = $clog2(NUM_VALUES);
    localparam int DEPTH = NUM_CLASSES * NUM_FEATURES * NUM_VALUES;
    localparam int AB    = $clog2(DEPTH);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int NF4   = 4;   // feature ports carried on the interface

    logic [COUNT_BITS-1:0] r_total;
    logic [COUNT_BITS-1:0] r_ccount [NUM_CLASSES];
    logic [COUNT_BITS-1:0] r_mem [DEPTH];
    logic [COUNT_BITS-1:0] r_rd;
    logic [AB:0]           r_clr;
    logic [15:0]           r_feats;
    logic [2:0]            r_label;
    logic                  r_train_ok;
    logic [CB:0]           r_cls;
    logic [FB:0]           r_feat;
    logic [16:0]           r_score, r_best;
    logic [2:0]            r_best_lbl;
    logic                  r_have;
    logic                  r_fv_ok;
    logic [FB:0]           w_fsel;
    logic [3:0]            w_val;
    logic                  w_val_ok;
    logic [AB-1:0]         w_addr;
    logic [CB-1:0]         w_cls;
    logic [CB-1:0]         w_lab;
    logic                  div_start, div_busy;
    logic [COUNT_BITS-1:0] div_num, div_den;
    logic [16:0]           div_q;
    logic [33:0]           w_prod;

    assign w_lab = CB'(r_label);
    assign w_cls = i_cmd.tr_read || i_cmd.tr_write ? w_lab : r_cls[CB-1:0];

    always_comb begin
        // during the multiply the count of the next feature is fetched
        w_fsel = (i_cmd.mul && i_cmd.fv_read) ? r_feat + 1'b1 : r_feat;
        w_val = 4'(r_feats >> (4 * 32'(w_fsel)));
        w_val_ok = (w_fsel < (FB+1)'(NF4)) && ({28'b0, w_val} < NUM_VALUES);
        w_addr = AB'((32'(w_cls) * NUM_FEATURES + 32'(w_fsel)) * NUM_VALUES + 32'(w_val));
    end

    // count memory: clear sweep, read, write
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step && !r_clr[AB]) r_mem[r_clr[AB-1:0]] <= '0;
        else if (i_cmd.tr_write && r_train_ok && r_fv_ok && r_rd != CMAX)
            r_mem[w_addr] <= r_rd + 1'b1;
        r_rd <= r_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_total <= '0;
            for (int i = 0; i < NUM_CLASSES; i++) r_ccount[i] <= '0;
        end else begin
            if (i_cmd.clr_step && !r_clr[AB]) r_clr <= r_clr + 1'b1;
            if (i_cmd.tr_capture && !i_label_in && {29'b0, i_label} < NUM_CLASSES) begin
                if (r_total != CMAX) r_total <= r_total + 1'b1;
                if (r_ccount[CB'(i_label)] != CMAX)
                    r_ccount[CB'(i_label)] <= r_ccount[CB'(i_label)] + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tr_capture) begin
            r_feats    <= i_feats;
            r_label    <= i_label;
            r_train_ok <= ({29'b0, i_label} < NUM_CLASSES);
            r_feat     <= '0;
            r_cls      <= '0;
            r_have     <= 1'b0;
            r_best     <= '0;
            r_best_lbl <= '0;
        end
        if (i_cmd.tr_read || i_cmd.fv_read) r_fv_ok <= w_val_ok;
        if (i_cmd.next_feat)
            r_feat <= (i_cmd.tr_write && o_sts.tr_last) || (i_cmd.mul && o_sts.feat_last)
                      ? '0 : r_feat + 1'b1;
        if (i_cmd.div_prior) r_feat <= '0;
        // prior result arrives at the first fv_read
        if (i_cmd.fv_read && !i_cmd.mul) r_score <= div_q;
        if (i_cmd.mul) r_score <= (w_prod[33:16] > 18'h1FFFF) ? '1 : w_prod[32:16];
        if (i_cmd.skip_cls) r_cls <= r_cls + 1'b1;
        if (i_cmd.cmp) begin
            r_cls <= r_cls + 1'b1;
            if (!r_have || r_score > r_best) begin
                r_have     <= 1'b1;
                r_best     <= r_score;
                r_best_lbl <= 3'(r_cls);
            end
        end
    end

    assign div_start = i_cmd.div_prior || i_cmd.div_ratio;
    assign div_num = i_cmd.div_prior ? r_ccount[w_cls] : (r_fv_ok ? r_rd : '0);
    assign div_den = i_cmd.div_prior ? r_total : r_ccount[w_cls];
    assign w_prod  = 34'(r_score) * 34'(div_q);

    cnb_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_busy(div_busy), .o_quot(div_q)
    );

    always_comb begin
        o_sts.clr_done  = r_clr[AB];
        o_sts.tr_last   = (r_feat == (FB+1)'(NUM_FEATURES - 1));
        o_sts.feat_last = (r_feat == (FB+1)'(NUM_FEATURES - 1));
        o_sts.cls_zero  = (r_ccount[w_cls] == '0);
        o_sts.cls_last  = (r_cls == (CB+1)'(NUM_CLASSES - 1));
        o_sts.div_busy  = div_busy;
    end

    assign o_predicted_label = r_best_lbl;
    assign o_label_valid     = r_have;
endmodule

@@ rtl/categorical_naive_bayes_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// categorical_naive_bayes_classifier: top level
// Trains categorical count tables and predicts the most likely class.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall): one transfer per item. i_mode = 0
//   trains with i_label and the four features; i_mode = 1 predicts.
//   Output channel (o_valid / i_stall): one transfer per predict item,
//   none for a train item.
// Sequencing:
//   Train does one read and one write of the count memory per feature.
//   Predict walks every class through one shared bit-serial divider,
//   once per feature plus once for the prior; an untrained class is
//   skipped without a division. The result then goes to the output.
// Reset:
//   A clearing pass writes zero into all NUM_CLASSES*NUM_FEATURES*
//   NUM_VALUES count entries, one per cycle; o_stall stays high meanwhile.
// Stall:
//   The result holds on the output until taken; no new item is accepted
//   before that.
// ----------------------------------------------------------------------------
module categorical_naive_bayes_classifier #(
    parameter int NUM_CLASSES  = 8,
    parameter int NUM_FEATURES = 4,
    parameter int NUM_VALUES   = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [2:0] i_label,
    input  logic [3:0] i_feature_0,
    input  logic [3:0] i_feature_1,
    input  logic [3:0] i_feature_2,
    input  logic [3:0] i_feature_3,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_predicted_label,
    output logic       o_label_valid
);
    import cnb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    cnb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_mode(i_mode),
        .i_out_stall(i_stall), .i_sts(w_sts), .o_stall(o_stall),
        .o_valid(o_valid), .o_cmd(w_cmd)
    );

    cnb_datapath #(
        .NUM_CLASSES(NUM_CLASSES), .NUM_FEATURES(NUM_FEATURES),
        .NUM_VALUES(NUM_VALUES), .COUNT_BITS(COUNT_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_label_in(i_mode), .i_label(i_label),
        .i_feats({i_feature_3, i_feature_2, i_feature_1, i_feature_0}),
        .o_sts(w_sts), .o_predicted_label(o_predicted_label),
        .o_label_valid(o_label_valid)
    );
endmodule

@@ rtl/cnb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnb_checker: port-level checks
// ----------------------------------------------------------------------------
module cnb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [2:0] o_predicted_label,
    input logic       o_label_valid
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_predicted_label))
        else $error("result dropped under stall");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");
    a_inv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_label_valid |-> o_predicted_label == 3'd0)
        else $error("label without training");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input taken while busy");
endmodule

bind categorical_naive_bayes_classifier cnb_checker u_chk (.*);
